/* design/fcl_pkg.sv */
// Shared types and constants of the 2D friction contact local solver.
`default_nettype none
package fcl_pkg;

    localparam int VW      = 32;  // value field width
    localparam int MUW     = 16;  // friction coefficient width
    localparam int MU_BITS = 12;  // fraction bits of the friction coefficient
    localparam int QDEPTH  = 8;   // job queue depth
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QLW     = QAW + 1;

    typedef enum logic [1:0] {
        MODE_SEPARATED  = 2'd0,
        MODE_STICK      = 2'd1,
        MODE_SLIDE_NEG  = 2'd2,
        MODE_SLIDE_POS  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_ZERO_DIV = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_SOLVE = 2'd0,
        KIND_SEP   = 2'd1,
        KIND_SING  = 2'd2
    } t_kind;

    // classified contact handed from front to back
    typedef struct packed {
        logic signed [31:0] wnn;
        logic signed [31:0] wnt;
        logic signed [31:0] qn;
        logic [15:0]        mu;
        logic signed [63:0] d;
        logic signed [63:0] num0;
        logic signed [63:0] num1;
        t_kind              kind;
    } t_job;

endpackage
`default_nettype wire

/* design/fcl_ifs.sv */
// Valid/ready channel interfaces for contact items and solver results.
`default_nettype none
interface fcl_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] w_normal_normal;
    logic signed [31:0] w_tangent_normal;
    logic signed [31:0] w_normal_tangent;
    logic signed [31:0] w_tangent_tangent;
    logic signed [31:0] free_normal;
    logic signed [31:0] free_tangent;
    logic [15:0]        friction_coeff;

    modport source (
        output valid, w_normal_normal, w_tangent_normal, w_normal_tangent,
               w_tangent_tangent, free_normal, free_tangent, friction_coeff,
        input  ready
    );
    modport sink (
        input  valid, w_normal_normal, w_tangent_normal, w_normal_tangent,
               w_tangent_tangent, free_normal, free_tangent, friction_coeff,
        output ready
    );
endinterface

interface fcl_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] normal_reaction;
    logic signed [31:0] tangent_reaction;
    logic [1:0]         contact_mode;
    logic [1:0]         status;

    modport source (
        output valid, normal_reaction, tangent_reaction, contact_mode, status,
        input  ready
    );
    modport sink (
        input  valid, normal_reaction, tangent_reaction, contact_mode, status,
        output ready
    );
endinterface
`default_nettype wire

/* design/fcl_front.sv */
// Front end: accepts contacts, forms determinant and Cramer numerators, classifies.
`default_nettype none
module fcl_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fcl_item_if.sink                    i_item,
    input  logic [31:0]                 i_threshold,
    input  logic [fcl_pkg::QLW-1:0]     i_q_level,
    output logic                        o_push,
    output fcl_pkg::t_job               o_job
);
    import fcl_pkg::*;

    logic               w_acc;
    logic [QLW:0]       w_used;
    logic               r_s1_v, r_s2_v;
    logic signed [31:0] r_wnn, r_wtn, r_wnt, r_wtt, r_qn, r_qt;
    logic [15:0]        r_mu;
    logic signed [63:0] r_p_d0, r_p_d1, r_p_n0a, r_p_n0b, r_p_n1a, r_p_n1b;
    logic signed [31:0] r_s2_wnn, r_s2_wnt, r_s2_qn;
    logic [15:0]        r_s2_mu;
    logic signed [63:0] w_d, w_num0, w_num1;
    t_kind              w_kind;

    // count queue entries plus items still in flight here
    assign w_used = (QLW+1)'(i_q_level) + (QLW+1)'(r_s1_v) + (QLW+1)'(r_s2_v);
    assign i_item.ready = w_used < (QLW+1)'(QDEPTH);
    assign w_acc = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= w_acc;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_wnn <= i_item.w_normal_normal;
            r_wtn <= i_item.w_tangent_normal;
            r_wnt <= i_item.w_normal_tangent;
            r_wtt <= i_item.w_tangent_tangent;
            r_qn  <= i_item.free_normal;
            r_qt  <= i_item.free_tangent;
            r_mu  <= i_item.friction_coeff;
        end
        r_p_d0   <= 64'(r_wnn) * 64'(r_wtt);
        r_p_d1   <= 64'(r_wnt) * 64'(r_wtn);
        r_p_n0a  <= 64'(r_wnt) * 64'(r_qt);
        r_p_n0b  <= 64'(r_wtt) * 64'(r_qn);
        r_p_n1a  <= 64'(r_wtn) * 64'(r_qn);
        r_p_n1b  <= 64'(r_wnn) * 64'(r_qt);
        r_s2_wnn <= r_wnn;
        r_s2_wnt <= r_wnt;
        r_s2_qn  <= r_qn;
        r_s2_mu  <= r_mu;
    end

    assign w_d    = r_p_d0 - r_p_d1;
    assign w_num0 = r_p_n0a - r_p_n0b;
    assign w_num1 = r_p_n1a - r_p_n1b;

    always_comb begin
        if (r_s2_qn > 32'sd0) begin
            w_kind = KIND_SEP;
        end else if (w_d <= 64'sd0 || $unsigned(w_d) < {32'd0, i_threshold}) begin
            w_kind = KIND_SING;
        end else begin
            w_kind = KIND_SOLVE;
        end
    end

    assign o_push    = r_s2_v;
    assign o_job.wnn  = r_s2_wnn;
    assign o_job.wnt  = r_s2_wnt;
    assign o_job.qn   = r_s2_qn;
    assign o_job.mu   = r_s2_mu;
    assign o_job.d    = w_d;
    assign o_job.num0 = w_num0;
    assign o_job.num1 = w_num1;
    assign o_job.kind = w_kind;

endmodule
`default_nettype wire

/* design/fcl_queue.sv */
// Job queue between front end and back end.
`default_nettype none
module fcl_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  fcl_pkg::t_job           i_job,
    input  logic                    i_pop,
    output fcl_pkg::t_job           o_job,
    output logic                    o_empty,
    output logic [fcl_pkg::QLW-1:0] o_level
);
    import fcl_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QLW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + QLW'(i_push) - QLW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    assign o_job   = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_level = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count < QLW'(QDEPTH)))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == QLW'($past(r_count) + 1'b1)))
        else $error("queue level out of step with pushes");

endmodule
`default_nettype wire

/* design/fcl_div.sv */
// Pipelined restoring divider with 32-bit saturated signed quotient and sideband.
`default_nettype none
module fcl_div #(
    parameter int MW   = 64,
    parameter int SH   = 16,
    parameter int DENW = 64,
    parameter int SBW  = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_neg,
    input  logic [MW-1:0]      i_mag,
    input  logic [DENW-1:0]    i_den,
    input  logic [SBW-1:0]     i_sb,
    output logic               o_valid,
    output logic signed [31:0] o_quot,
    output logic [SBW-1:0]     o_sb
);
    import fcl_pkg::*;

    localparam int DW = MW + SH;
    localparam int HW = DW - VW;
    localparam int CW = (HW > DENW) ? HW : DENW;
    localparam int NS = VW;

    logic            r0_v, r0_neg;
    logic [DW-1:0]   r0_div;
    logic [DENW-1:0] r0_den;
    logic [SBW-1:0]  r0_sb;

    logic            r_v   [NS+1];
    logic            r_neg [NS+1];
    logic            r_ovf [NS+1];
    logic [DENW-1:0] r_rem [NS+1];
    logic [VW-1:0]   r_lo  [NS+1];
    logic [VW-1:0]   r_q   [NS+1];
    logic [DENW-1:0] r_den [NS+1];
    logic [SBW-1:0]  r_sb  [NS+1];

    logic [HW-1:0]   w_top;
    logic            w_ovf;
    logic [DENW:0]   w_t    [NS];
    logic [DENW:0]   w_sub  [NS];
    logic            w_ge   [NS];
    logic [DENW-1:0] w_nrem [NS];
    logic [VW-1:0]   w_qf;

    // quotient bits above 32 exist exactly when the high part reaches the divisor
    assign w_top = r0_div[DW-1:VW];
    assign w_ovf = CW'(w_top) >= CW'(r0_den);

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_t[k]    = {r_rem[k], r_lo[k][VW-1]};
            w_sub[k]  = w_t[k] - {1'b0, r_den[k]};
            w_ge[k]   = w_t[k] >= {1'b0, r_den[k]};
            w_nrem[k] = w_ge[k] ? w_sub[k][DENW-1:0] : w_t[k][DENW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            for (int k = 0; k <= NS; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r0_v   <= i_valid;
            r_v[0] <= r0_v;
            for (int k = 0; k < NS; k++) r_v[k+1] <= r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_neg   <= i_neg;
            r0_div   <= {i_mag, {SH{1'b0}}};
            r0_den   <= i_den;
            r0_sb    <= i_sb;
            r_neg[0] <= r0_neg;
            r_ovf[0] <= w_ovf;
            r_rem[0] <= DENW'(w_top);
            r_lo[0]  <= r0_div[VW-1:0];
            r_q[0]   <= '0;
            r_den[0] <= r0_den;
            r_sb[0]  <= r0_sb;
            for (int k = 0; k < NS; k++) begin
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                r_rem[k+1] <= w_nrem[k];
                r_lo[k+1]  <= {r_lo[k][VW-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][VW-2:0], w_ge[k]};
                r_den[k+1] <= r_den[k];
                r_sb[k+1]  <= r_sb[k];
            end
        end
    end

    assign w_qf = r_q[NS];

    always_comb begin
        if (!r_neg[NS]) begin
            if (r_ovf[NS] || w_qf[VW-1]) o_quot = 32'sh7FFFFFFF;
            else                          o_quot = $signed(w_qf);
        end else begin
            if (r_ovf[NS] || w_qf > 32'h80000000) o_quot = 32'sh80000000;
            else                                   o_quot = $signed(-w_qf);
        end
    end

    assign o_valid = r_v[NS];
    assign o_sb    = r_sb[NS];

endmodule
`default_nettype wire

/* design/fcl_back.sv */
// Back end: Cramer division, cone test, edge projection and result register.
`default_nettype none
module fcl_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fcl_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    fcl_result_if.source  o_result
);
    import fcl_pkg::*;

    localparam int PW     = 50;             // product and slip divisor width
    localparam int EDW    = VW + MUW + 1;   // slip divisor magnitude width
    localparam int SBA    = 2 * VW + MUW;
    localparam int SBB    = VW + 2;
    localparam int SBE    = 1 + 1 + 2 + 2 + 2 * VW + MUW;

    logic               w_adv;
    logic               r_b0_v;
    t_job               r_b0;
    logic [63:0]        w_mag0, w_mag1;

    logic               w_pn_v, w_pt_v;
    logic signed [31:0] w_pn, w_pt;
    logic [SBA-1:0]     w_sba;
    logic [SBB-1:0]     w_sbb;

    logic               r_c1_v;
    logic signed [31:0] r_c1_pn, r_c1_pt, r_c1_qn;
    logic [15:0]        r_c1_mu;
    t_kind              r_c1_kind;
    logic signed [PW-1:0] r_c1_mupn, r_c1_ptw, r_c1_wsc, r_c1_muwnt;
    logic signed [PW-1:0] w_abs_ptw, w_side_sum;

    logic               r_c2_v, r_c2_out, r_c2_negside;
    logic signed [31:0] r_c2_pn, r_c2_pt, r_c2_qn;
    logic [15:0]        r_c2_mu;
    t_kind              r_c2_kind;
    logic signed [PW-1:0] r_c2_dp, r_c2_dm;

    logic signed [PW-1:0] w_den, w_den_abs;
    logic               w_den_zero, w_edge;
    logic [31:0]        w_qn_mag;
    t_mode              w_mode;
    t_status            w_status;
    logic signed [31:0] w_pn_sel, w_pt_sel;

    logic               w_e_v;
    logic signed [31:0] w_e_pn;
    logic [SBE-1:0]     w_sbe;
    logic               w_e_edge, w_e_negside;
    logic [1:0]         w_e_mode, w_e_status;
    logic signed [31:0] w_e_pnsel, w_e_ptsel;
    logic [15:0]        w_e_mu;
    logic signed [31:0] w_e_pnf;

    logic               r_e1_v, r_e1_edge, r_e1_negside;
    logic [1:0]         r_e1_mode, r_e1_status;
    logic signed [31:0] r_e1_pn, r_e1_ptsel;
    logic signed [PW-1:0] r_e1_mupn;
    logic [PW-1:0]      w_mp_mag, w_m;
    logic               w_mp_neg;
    logic signed [31:0] w_pt_edge, w_pt_fin;

    logic               r_out_v;
    logic signed [31:0] r_out_pn, r_out_pt;
    logic [1:0]         r_out_mode, r_out_status;

    // whole back end holds while the result register is full and not taken
    assign w_adv = !r_out_v || o_result.ready;
    assign o_pop = w_adv && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            r_e1_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_b0_v  <= o_pop;
            r_c1_v  <= w_pn_v & w_pt_v;
            r_c2_v  <= r_c1_v;
            r_e1_v  <= w_e_v;
            r_out_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_b0 <= i_job;
    end

    assign w_mag0 = r_b0.num0[63] ? 64'(-r_b0.num0) : 64'(r_b0.num0);
    assign w_mag1 = r_b0.num1[63] ? 64'(-r_b0.num1) : 64'(r_b0.num1);

    fcl_div #(.MW(64), .SH(FRAC_BITS), .DENW(64), .SBW(SBA)) u_div_pn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_b0_v),
        .i_neg   (r_b0.num0[63]),
        .i_mag   (w_mag0),
        .i_den   (r_b0.d),
        .i_sb    ({r_b0.wnn, r_b0.wnt, r_b0.mu}),
        .o_valid (w_pn_v),
        .o_quot  (w_pn),
        .o_sb    (w_sba)
    );

    fcl_div #(.MW(64), .SH(FRAC_BITS), .DENW(64), .SBW(SBB)) u_div_pt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_b0_v),
        .i_neg   (r_b0.num1[63]),
        .i_mag   (w_mag1),
        .i_den   (r_b0.d),
        .i_sb    ({r_b0.qn, r_b0.kind}),
        .o_valid (w_pt_v),
        .o_quot  (w_pt),
        .o_sb    (w_sbb)
    );

    // cone products and slip divisor terms
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c1_pn    <= w_pn;
            r_c1_pt    <= w_pt;
            r_c1_qn    <= w_sbb[SBB-1:2];
            r_c1_kind  <= t_kind'(w_sbb[1:0]);
            r_c1_mu    <= w_sba[MUW-1:0];
            r_c1_mupn  <= PW'($signed({1'b0, w_sba[MUW-1:0]})) * PW'(w_pn);
            r_c1_ptw   <= PW'(w_pt) <<< MU_BITS;
            r_c1_wsc   <= PW'($signed(w_sba[SBA-1 -: VW])) <<< MU_BITS;
            r_c1_muwnt <= PW'($signed({1'b0, w_sba[MUW-1:0]}))
                        * PW'($signed(w_sba[MUW +: VW]));
        end
    end

    assign w_abs_ptw  = r_c1_ptw[PW-1] ? -r_c1_ptw : r_c1_ptw;
    assign w_side_sum = r_c1_ptw + r_c1_mupn;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c2_out     <= w_abs_ptw > r_c1_mupn;
            r_c2_negside <= w_side_sum[PW-1];
            r_c2_dp      <= r_c1_wsc + r_c1_muwnt;
            r_c2_dm      <= r_c1_wsc - r_c1_muwnt;
            r_c2_pn      <= r_c1_pn;
            r_c2_pt      <= r_c1_pt;
            r_c2_qn      <= r_c1_qn;
            r_c2_mu      <= r_c1_mu;
            r_c2_kind    <= r_c1_kind;
        end
    end

    assign w_den      = r_c2_negside ? r_c2_dm : r_c2_dp;
    assign w_den_zero = (w_den == '0);
    assign w_den_abs  = w_den[PW-1] ? -w_den : w_den;
    assign w_qn_mag   = 32'(-(33'(r_c2_qn)));

    always_comb begin
        w_edge   = 1'b0;
        w_mode   = MODE_SEPARATED;
        w_status = ST_OK;
        w_pn_sel = '0;
        w_pt_sel = '0;
        unique case (r_c2_kind)
            KIND_SEP: begin
            end
            KIND_SING: begin
                w_status = ST_SINGULAR;
            end
            KIND_SOLVE: begin
                if (!r_c2_out) begin
                    w_mode   = MODE_STICK;
                    w_pn_sel = r_c2_pn;
                    w_pt_sel = r_c2_pt;
                end else if (w_den_zero) begin
                    w_status = ST_ZERO_DIV;
                end else begin
                    w_edge = 1'b1;
                    w_mode = r_c2_negside ? MODE_SLIDE_NEG : MODE_SLIDE_POS;
                end
            end
            default: begin
            end
        endcase
    end

    fcl_div #(.MW(VW), .SH(FRAC_BITS + MU_BITS), .DENW(EDW), .SBW(SBE)) u_div_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_c2_v),
        .i_neg   (w_den[PW-1]),
        .i_mag   (w_qn_mag),
        .i_den   (w_den_abs[EDW-1:0]),
        .i_sb    ({w_edge, r_c2_negside, w_mode, w_status, w_pn_sel, w_pt_sel, r_c2_mu}),
        .o_valid (w_e_v),
        .o_quot  (w_e_pn),
        .o_sb    (w_sbe)
    );

    assign {w_e_edge, w_e_negside, w_e_mode, w_e_status, w_e_pnsel, w_e_ptsel, w_e_mu} = w_sbe;
    assign w_e_pnf = w_e_edge ? w_e_pn : w_e_pnsel;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e1_edge    <= w_e_edge;
            r_e1_negside <= w_e_negside;
            r_e1_mode    <= w_e_mode;
            r_e1_status  <= w_e_status;
            r_e1_pn      <= w_e_pnf;
            r_e1_ptsel   <= w_e_ptsel;
            r_e1_mupn    <= PW'($signed({1'b0, w_e_mu})) * PW'(w_e_pn);
        end
    end

    // scale mu*Pn back by the coefficient's fraction bits, toward zero
    assign w_mp_mag = r_e1_mupn[PW-1] ? PW'(-r_e1_mupn) : PW'(r_e1_mupn);
    assign w_mp_neg = r_e1_negside ^ r_e1_mupn[PW-1];
    assign w_m      = w_mp_mag >> MU_BITS;

    always_comb begin
        if (!w_mp_neg) begin
            if (w_m > PW'(32'h7FFFFFFF)) w_pt_edge = 32'sh7FFFFFFF;
            else                          w_pt_edge = $signed(w_m[31:0]);
        end else begin
            if (w_m > PW'(32'h80000000)) w_pt_edge = 32'sh80000000;
            else                          w_pt_edge = $signed(-w_m[31:0]);
        end
    end

    assign w_pt_fin = r_e1_edge ? w_pt_edge : r_e1_ptsel;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pn     <= r_e1_pn;
            r_out_pt     <= w_pt_fin;
            r_out_mode   <= r_e1_mode;
            r_out_status <= r_e1_status;
        end
    end

    assign o_result.valid            = r_out_v;
    assign o_result.normal_reaction  = r_out_pn;
    assign o_result.tangent_reaction = r_out_pt;
    assign o_result.contact_mode     = r_out_mode;
    assign o_result.status           = r_out_status;

endmodule
`default_nettype wire

/* design/friction_contact_2d_local_solve.sv */
// Throughput: one contact per cycle while the output is not stalled and the queue has
// room; every stage, the three dividers included, is fully pipelined. An 8-entry job
// queue parts the front end from the back end, so items keep entering while a result
// waits, until the queue fills. Reset (synchronous, active low) empties all pipelines
// and the queue and sets singular_threshold to 1.
`default_nettype none
module friction_contact_2d_local_solve #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fcl_item_if.sink     i_item,
    fcl_result_if.source o_result,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import fcl_pkg::*;

    localparam logic REG_SINGULAR_THRESHOLD = 1'b0;

    logic [31:0]    r_threshold;
    logic           w_push, w_pop, w_empty;
    t_job           w_push_job, w_pop_job;
    logic [QLW-1:0] w_level;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 32'd1;
        end else if (psel && penable && pwrite && paddr[2] == REG_SINGULAR_THRESHOLD) begin
            r_threshold <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_SINGULAR_THRESHOLD) ? r_threshold : 32'd0;

    fcl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_threshold (r_threshold),
        .i_q_level   (w_level),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    fcl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty),
        .o_level (w_level)
    );

    fcl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_pop_job),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

/* test/tb_ifs_note.sv */
// Testbench-side helper types for the friction contact solver regression.
`timescale 1ns / 100ps
package tb_fcl_types;
    typedef struct packed {
        logic signed [31:0] wnn;
        logic signed [31:0] wtn;
        logic signed [31:0] wnt;
        logic signed [31:0] wtt;
        logic signed [31:0] qn;
        logic signed [31:0] qt;
        logic [15:0]        mu;
    } t_contact;

    typedef struct packed {
        logic signed [31:0] pn;
        logic signed [31:0] pt;
        logic [1:0]         mode;
        logic [1:0]         status;
    } t_reaction;
endpackage

/* test/tb_top.sv */
// Regression testbench for the 2D friction contact local solver.
`timescale 1ns / 100ps
module tb_top;
    import fcl_pkg::*;
    import tb_fcl_types::*;

    localparam int FB = 16;
    localparam int LATENCY = 76;
    localparam int WATCHDOG = 20000;
    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    fcl_item_if   item_ch();
    fcl_result_if result_ch();

    friction_contact_2d_local_solve #(.FRAC_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink),
        .o_result(result_ch.source), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    t_contact  pending_contacts[$];
    t_reaction expected_reactions[$];
    logic [31:0] threshold_q = 32'd1;
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  sender_hold = 0;
    bit  tx_taken = 0;
    int  rx_hold_cycles = 0;
    int  tx_gap = 0, rx_gap = 0;

    // Draw a gap length: mostly zero, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [31:0] sat_q(bit neg, logic [127:0] q);
        if (!neg) return (q > 128'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
        if (q > 128'h80000000) return 32'sh80000000;
        return -q[31:0];
    endfunction

    // Signed quotient (mag << sh) / den, truncated toward zero and saturated.
    function automatic logic signed [31:0] scaled_quotient(bit neg, logic [63:0] mag,
                                                           int sh, logic [63:0] den);
        logic [127:0] num;
        num = {64'd0, mag} << sh;
        return sat_q(neg, num / {64'd0, den});
    endfunction

    function automatic logic [63:0] mag_of(logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic t_reaction solve_contact(t_contact c, logic [31:0] thr);
        t_reaction r;
        logic signed [63:0] d, num0, num1, mupn, ptw, wscaled, den, s, prod;
        logic signed [63:0] mu;
        bit negside;
        logic [63:0] m;
        r = '0;
        mu = {48'd0, c.mu};
        if (c.qn <= 0) begin
            d = 64'(c.wnn) * 64'(c.wtt) - 64'(c.wnt) * 64'(c.wtn);
            if (d <= 0 || d < {32'd0, thr}) begin
                r.status = ST_SINGULAR;
            end else begin
                num0 = 64'(c.wnt) * 64'(c.qt) - 64'(c.wtt) * 64'(c.qn);
                num1 = 64'(c.wtn) * 64'(c.qn) - 64'(c.wnn) * 64'(c.qt);
                r.pn = scaled_quotient(num0 < 0, mag_of(num0), FB, d);
                r.pt = scaled_quotient(num1 < 0, mag_of(num1), FB, d);
                mupn = mu * 64'(r.pn);
                ptw = 64'(r.pt) <<< MU_BITS;
                r.mode = MODE_STICK;
                if ($signed(mag_of(ptw)) > mupn) begin
                    negside = (ptw + mupn) < 0;
                    wscaled = 64'(c.wnn) <<< MU_BITS;
                    den = negside ? wscaled - mu * 64'(c.wnt) : wscaled + mu * 64'(c.wnt);
                    if (den == 0) begin
                        r = '0;
                        r.status = ST_ZERO_DIV;
                    end else begin
                        s = -64'(c.qn);
                        r.pn = scaled_quotient((s < 0) != (den < 0), mag_of(s),
                                               FB + MU_BITS, mag_of(den));
                        prod = negside ? -(mu * 64'(r.pn)) : mu * 64'(r.pn);
                        m = mag_of(prod) >> MU_BITS;
                        r.pt = sat_q(prod < 0, {64'd0, m});
                        r.mode = negside ? MODE_SLIDE_NEG : MODE_SLIDE_POS;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    task automatic write_threshold(logic [31:0] value);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1; paddr = ADDR_THRESHOLD; pwdata = value;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        threshold_q = value;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic wait_drained();
        while (pending_contacts.size() != 0 || expected_reactions.size() != 0 ||
               item_ch.valid)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rnd_val();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
            3: return $signed($urandom_range(0, 255)) - 128;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a well-posed contact (dominant diagonal, approaching or separating), else random extreme values.
    function automatic t_contact rnd_contact();
        t_contact c;
        if ($urandom_range(9) < 7) begin
            c.wnn = $urandom_range(32'h0000_8000, 32'h0004_0000);
            c.wtt = $urandom_range(32'h0000_8000, 32'h0004_0000);
            c.wnt = $signed($urandom_range(0, 32'h0000_8000)) - 32'sh4000;
            c.wtn = $urandom_range(1) ? c.wnt : $signed($urandom_range(0, 32'h8000)) - 32'sh4000;
            c.qn  = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0003_0000;
            c.qt  = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            c.mu  = $urandom_range(1) ? 16'($urandom_range(0, 16'h2000)) : 16'($urandom);
        end else begin
            c.wnn = rnd_val(); c.wtn = rnd_val(); c.wnt = rnd_val(); c.wtt = rnd_val();
            c.qn = rnd_val(); c.qt = rnd_val(); c.mu = 16'($urandom);
        end
        return c;
    endfunction

    function automatic t_contact mk(int wnn, int wtn, int wnt, int wtt, int qn, int qt,
                                    int mu);
        t_contact c;
        c.wnn = wnn; c.wtn = wtn; c.wnt = wnt; c.wtt = wtt;
        c.qn = qn; c.qt = qt; c.mu = mu[15:0];
        return c;
    endfunction

    // Record whether the offered contact was taken at this rising edge.
    always @(posedge i_clk) begin
        tx_taken <= item_ch.valid && item_ch.ready;
    end

    // Driver: advance to the next contact or idle at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (!item_ch.valid || tx_taken) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                item_ch.valid <= 1'b0;
            end else if (pending_contacts.size() != 0 && !sender_hold) begin
                {item_ch.w_normal_normal, item_ch.w_tangent_normal, item_ch.w_normal_tangent,
                 item_ch.w_tangent_tangent, item_ch.free_normal, item_ch.free_tangent,
                 item_ch.friction_coeff} <= pending_contacts.pop_front();
                item_ch.valid <= 1'b1;
                tx_gap <= pick_gap();
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    initial begin
        item_ch.valid = 0;
        {item_ch.w_normal_normal, item_ch.w_tangent_normal, item_ch.w_normal_tangent,
         item_ch.w_tangent_tangent, item_ch.free_normal, item_ch.free_tangent,
         item_ch.friction_coeff} = '0;
        result_ch.ready = 0;
    end

    // Receiver backpressure, with a forced long hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            result_ch.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
            rx_gap <= pick_gap();
        end
    end

    // Monitor: predict on input transactions, check on output transactions.
    always @(posedge i_clk) begin
        t_reaction want;
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready)
                expected_reactions.push_back(solve_contact({item_ch.w_normal_normal,
                    item_ch.w_tangent_normal, item_ch.w_normal_tangent,
                    item_ch.w_tangent_tangent, item_ch.free_normal, item_ch.free_tangent,
                    item_ch.friction_coeff}, threshold_q));
            if (result_ch.valid && result_ch.ready) begin
                if (expected_reactions.size() == 0) begin
                    report_mismatch("unexpected result", result_ch.normal_reaction, 32'd0);
                end else begin
                    want = expected_reactions.pop_front();
                    if (result_ch.normal_reaction !== want.pn)
                        report_mismatch("normal_reaction", result_ch.normal_reaction, want.pn);
                    if (result_ch.tangent_reaction !== want.pt)
                        report_mismatch("tangent_reaction", result_ch.tangent_reaction, want.pt);
                    if (result_ch.contact_mode !== want.mode)
                        report_mismatch("contact_mode", 32'(result_ch.contact_mode),
                                        32'(want.mode));
                    if (result_ch.status !== want.status)
                        report_mismatch("status", 32'(result_ch.status), 32'(want.status));
                end
            end
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] thresholds[4];
        thresholds = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd1};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        write_threshold(32'd1);

        // Directed: separation, singular, stick, both slide edges, extremes.
        pending_contacts.push_back(mk(32'h10000, 0, 0, 32'h10000, 1, 5, 100));
        pending_contacts.push_back(mk(32'h10000, 0, 0, 32'h10000, 32'h7FFFFFFF, 0, 0));
        pending_contacts.push_back(mk(0, 0, 0, 0, -32'h10000, 0, 4096));
        pending_contacts.push_back(mk(32'h10000, 32'h10000, 32'h10000, 32'h10000, -1, 0, 1));
        pending_contacts.push_back(mk(32'h10000, 0, 0, 32'h10000, -32'h10000, 0, 4096));
        pending_contacts.push_back(mk(32'h10000, 0, 0, 32'h10000, -32'h10000, 32'h30000, 4096));
        pending_contacts.push_back(mk(32'h10000, 0, 0, 32'h10000, -32'h10000, -32'h30000, 4096));
        pending_contacts.push_back(mk(32'h10000, 0, 32'h10000, 32'h20000, -32'h10000,
                                      32'h50000, 4096));
        pending_contacts.push_back(mk(32'h10000, 0, -32'h10000, 32'h20000, -32'h10000,
                                      -32'h50000, 4096));
        pending_contacts.push_back(mk(1, 0, 0, 1, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF));
        pending_contacts.push_back(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                      32'h80000000, 32'h80000000, 16'hFFFF));
        pending_contacts.push_back(mk(32'h80000000, 0, 0, 32'h80000000, 0, 32'h7FFFFFFF, 0));
        pending_contacts.push_back(mk(-1, -1, -1, -1, -1, -1, 16'hFFFF));
        pending_contacts.push_back(mk(32'h10000, 32'h5555, 32'hAAAA, 32'h10000, 0, 1, 16'h5555));
        pending_contacts.push_back(mk(32'h10000, 0, 0, 32'h10000, -32'h10000, 32'h20000, 0));
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            write_threshold(thresholds[phase]);
            // Stall the output for a long stretch while input keeps coming.
            if (phase == 1) rx_hold_cycles = 200;
            repeat (300) pending_contacts.push_back(rnd_contact());
            // Pause the sender mid-phase until every result has returned.
            if (phase == 2) begin
                while (pending_contacts.size() > 150) @(posedge i_clk);
                sender_hold = 1;
                while (expected_reactions.size() != 0 || item_ch.valid) @(posedge i_clk);
                sender_hold = 0;
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* friction_contact_2d_local_solve.f */
design/fcl_pkg.sv
design/fcl_ifs.sv
design/fcl_front.sv
design/fcl_queue.sv
design/fcl_div.sv
design/fcl_back.sv
design/friction_contact_2d_local_solve.sv
test/tb_ifs_note.sv
test/tb_top.sv
